@@ rtl/core/tild_pkg.sv @@
// Package for the tty input line discipline: item types, codes, register
// defaults and the command and status structs between controller and datapath.
// No dependencies.
package tild_pkg;

    localparam int BUFFER_DEPTH = 16;

    localparam int ENTRY_W  = 11;
    localparam int E_ESC    = 8;
    localparam int E_NL     = 9;
    localparam int E_EOF    = 10;

    localparam logic [1:0] C_BYTE  = 2'd0;
    localparam logic [1:0] C_READ  = 2'd1;
    localparam logic [1:0] C_FLUSH = 2'd2;
    localparam logic [1:0] C_RSVD  = 2'd3;

    localparam logic [2:0] K_ECHO  = 3'd0;
    localparam logic [2:0] K_INTR  = 3'd1;
    localparam logic [2:0] K_QUIT  = 3'd2;
    localparam logic [2:0] K_READ  = 3'd3;
    localparam logic [2:0] K_DONE  = 3'd4;

    localparam logic [1:0] RS_SUCCESS   = 2'd0;
    localparam logic [1:0] RS_WOULDBLK  = 2'd1;
    localparam logic [1:0] RS_NOTREADY  = 2'd2;

    localparam logic [2:0] CFG_IFLAGS = 3'd0;
    localparam logic [2:0] CFG_LFLAGS = 3'd1;
    localparam logic [2:0] CFG_CC     = 3'd2;
    localparam logic [2:0] CFG_LNEXT  = 3'd3;
    localparam logic [2:0] CFG_FG     = 3'd4;

    localparam logic [5:0]  IFLAGS_RST = 6'd4;
    localparam logic [6:0]  LFLAGS_RST = 7'd95;
    localparam logic [63:0] CC_RST     = 64'd1373910237895458820;
    localparam logic [7:0]  LNEXT_RST  = 8'd22;

    localparam int IF_STRIP = 0;
    localparam int IF_IGNCR = 1;
    localparam int IF_CRNL  = 2;
    localparam int IF_NLCR  = 3;
    localparam int IF_XON   = 4;
    localparam int IF_XANY  = 5;

    localparam int LF_CANON  = 0;
    localparam int LF_EXT    = 1;
    localparam int LF_SIG    = 2;
    localparam int LF_ECHO   = 3;
    localparam int LF_ECHOE  = 4;
    localparam int LF_ECHOK  = 5;
    localparam int LF_ECHONL = 6;

    localparam int CC_EOF   = 0;
    localparam int CC_EOL   = 1;
    localparam int CC_ERASE = 2;
    localparam int CC_INTR  = 3;
    localparam int CC_KILL  = 4;
    localparam int CC_QUIT  = 5;
    localparam int CC_START = 6;
    localparam int CC_STOP  = 7;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CARET = 8'h5e;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CTRL_LIM = 8'h20;
    localparam logic [7:0] STRIP_MASK = 8'h7f;

    localparam logic [4:0] KILL_ECHO_MAX = 5'd16;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] char_in;
        logic [4:0] read_size;
        logic       nonblock;
    } t_in_item;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data_byte;
        logic [1:0] read_status;
        logic [4:0] transferred;
        logic       readable;
        logic       last;
    } t_out_item;

    typedef enum logic [2:0] {
        A_NONE, A_STORE, A_ERASE, A_KILL, A_INTR, A_QUIT
    } t_act;

    typedef enum logic [2:0] {
        R_CHAR1, R_CHAR2, R_BS, R_SP, R_NL, R_SIG, R_RBYTE, R_RDONE
    } t_rsel;

    typedef struct packed {
        logic  accept;
        logic  classify;
        logic  rsetup;
        logic  emit;
        t_rsel sel;
        logic  pop;
        logic  kdec;
        logic  finish;
    } t_dp_cmd;

    typedef struct packed {
        t_act act_now;
        t_act act_q;
        logic echo_ch;
        logic caret;
        logic echo_on;
        logic echo_erase;
        logic kill_nl;
        logic go_now;
        logic rd_more;
        logic rd_emit;
        logic rd_stop;
        logic kcnt_one;
        logic emit_ok;
        logic out_free;
        logic pend_v;
    } t_dp_stat;

endpackage

@@ rtl/core/tild_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tild_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/tild_ctrl.sv @@
// Controller state machine of the tty input line discipline.
// Depends on tild_pkg for the command and status structs.
module tild_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [1:0]         i_in_cmd,
    input  tild_pkg::t_dp_stat i_stat,
    output tild_pkg::t_dp_cmd  o_cmd,
    output logic               o_idle
);

    typedef enum logic [13:0] {
        ST_IDLE   = 14'b00000000000001,
        ST_BYTE   = 14'b00000000000010,
        ST_ECHO_A = 14'b00000000000100,
        ST_ECHO_B = 14'b00000000001000,
        ST_TRI0   = 14'b00000000010000,
        ST_TRI1   = 14'b00000000100000,
        ST_TRI2   = 14'b00000001000000,
        ST_KNL    = 14'b00000010000000,
        ST_SIG    = 14'b00000100000000,
        ST_RSET   = 14'b00001000000000,
        ST_RREQ   = 14'b00010000000000,
        ST_RGET   = 14'b00100000000000,
        ST_RDONE  = 14'b01000000000000,
        ST_DONE   = 14'b10000000000000
    } t_state;

    t_state            r_state;
    t_state            n_state;
    tild_pkg::t_dp_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        cmd.sel = tild_pkg::R_CHAR1;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.accept = 1'b1;
                    if (i_in_cmd == tild_pkg::C_BYTE) begin
                        n_state = ST_BYTE;
                    end else if (i_in_cmd == tild_pkg::C_READ) begin
                        n_state = ST_RSET;
                    end
                end
            end
            ST_BYTE: begin
                cmd.classify = 1'b1;
                unique case (i_stat.act_now)
                    tild_pkg::A_STORE: n_state = ST_ECHO_A;
                    tild_pkg::A_ERASE: begin
                        if (!i_stat.echo_erase) begin
                            n_state = ST_ECHO_A;
                        end else if (i_stat.echo_on) begin
                            n_state = ST_TRI0;
                        end else begin
                            n_state = ST_DONE;
                        end
                    end
                    tild_pkg::A_KILL: begin
                        n_state = (i_stat.echo_erase && i_stat.echo_on) ? ST_TRI0 : ST_KNL;
                    end
                    tild_pkg::A_INTR, tild_pkg::A_QUIT: n_state = ST_SIG;
                    default: n_state = ST_DONE;
                endcase
            end
            ST_ECHO_A: begin
                cmd.sel = tild_pkg::R_CHAR1;
                if (!i_stat.echo_ch) begin
                    n_state = ST_DONE;
                end else if (i_stat.emit_ok) begin
                    cmd.emit = 1'b1;
                    n_state  = i_stat.caret ? ST_ECHO_B : ST_DONE;
                end
            end
            ST_ECHO_B: begin
                cmd.sel = tild_pkg::R_CHAR2;
                if (i_stat.emit_ok) begin
                    cmd.emit = 1'b1;
                    n_state  = ST_DONE;
                end
            end
            ST_TRI0: begin
                cmd.sel = tild_pkg::R_BS;
                if (i_stat.emit_ok) begin
                    cmd.emit = 1'b1;
                    n_state  = ST_TRI1;
                end
            end
            ST_TRI1: begin
                cmd.sel = tild_pkg::R_SP;
                if (i_stat.emit_ok) begin
                    cmd.emit = 1'b1;
                    n_state  = ST_TRI2;
                end
            end
            ST_TRI2: begin
                cmd.sel = tild_pkg::R_BS;
                if (i_stat.emit_ok) begin
                    cmd.emit = 1'b1;
                    cmd.kdec = 1'b1;
                    if (!i_stat.kcnt_one) begin
                        n_state = ST_TRI0;
                    end else if (i_stat.act_q == tild_pkg::A_KILL) begin
                        n_state = ST_KNL;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_KNL: begin
                cmd.sel = tild_pkg::R_NL;
                if (!i_stat.kill_nl) begin
                    n_state = ST_DONE;
                end else if (i_stat.emit_ok) begin
                    cmd.emit = 1'b1;
                    n_state  = ST_DONE;
                end
            end
            ST_SIG: begin
                cmd.sel = tild_pkg::R_SIG;
                if (i_stat.emit_ok) begin
                    cmd.emit = 1'b1;
                    n_state  = ST_DONE;
                end
            end
            ST_RSET: begin
                cmd.rsetup = 1'b1;
                n_state    = i_stat.go_now ? ST_RREQ : ST_RDONE;
            end
            ST_RREQ: begin
                n_state = i_stat.rd_more ? ST_RGET : ST_RDONE;
            end
            ST_RGET: begin
                cmd.sel = tild_pkg::R_RBYTE;
                if (!i_stat.rd_emit || i_stat.emit_ok) begin
                    cmd.pop  = 1'b1;
                    cmd.emit = i_stat.rd_emit;
                    n_state  = i_stat.rd_stop ? ST_RDONE : ST_RREQ;
                end
            end
            ST_RDONE: begin
                cmd.sel = tild_pkg::R_RDONE;
                if (i_stat.emit_ok) begin
                    cmd.emit = 1'b1;
                    n_state  = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!i_stat.pend_v) begin
                    n_state = ST_IDLE;
                end else if (i_stat.out_free) begin
                    cmd.finish = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_cmd  = cmd;
    assign o_idle = (r_state == ST_IDLE);

endmodule

@@ rtl/core/tild_dp.sv @@
// Datapath of the tty input line discipline: registers, byte classification,
// ring buffer state, read accounting and the result queue.
// Depends on tild_pkg and tild_ram.
module tild_dp #(
    parameter int DEPTH = tild_pkg::BUFFER_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tild_pkg::t_in_item  i_in_item,
    input  logic                i_cfg_valid,
    input  logic [2:0]          i_cfg_index,
    input  logic [63:0]         i_cfg_data,
    input  tild_pkg::t_dp_cmd   i_cmd,
    output tild_pkg::t_dp_stat  o_stat,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output tild_pkg::t_out_item o_out_item
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = (CW > 5) ? CW : 5;

    logic [5:0]  r_iflags;
    logic [6:0]  r_lflags;
    logic [63:0] r_cc;
    logic [7:0]  r_lnext;
    logic        r_fg;

    logic [IW-1:0] r_head;
    logic [CW-1:0] r_stored;
    logic [CW-1:0] r_lc;
    logic [CW-1:0] r_linelen;
    logic          r_esc;
    logic          r_stop;

    tild_pkg::t_in_item r_in;
    logic [7:0]    r_chb;
    logic          r_che;
    tild_pkg::t_act r_act;
    logic [4:0]    r_kcnt;
    logic          r_rd;
    logic [1:0]    r_rstat;
    logic [CW-1:0] r_tr;
    logic [CW-1:0] r_i;
    logic [CW-1:0] r_n;

    tild_pkg::t_out_item r_pend;
    logic                r_pend_v;
    tild_pkg::t_out_item r_out;
    logic                r_out_v;
    tild_pkg::t_out_item pend_last;

    logic [tild_pkg::ENTRY_W-1:0] rdata;
    logic [tild_pkg::ENTRY_W-1:0] wdata;
    logic [IW-1:0]                tail;
    logic [CW:0]                  tail_sum;

    logic [7:0]     b0;
    logic [7:0]     b1;
    logic           e;
    logic           skip;
    logic           n_esc_c;
    logic           n_stop_c;
    logic           stp;
    logic [7:0]     hit;
    logic           nl_c;
    logic           eof_c;
    tild_pkg::t_act act;
    logic           canon;
    logic           rd_byte;

    logic [SW-1:0]  size_x;
    logic [SW-1:0]  st_x;
    logic           all_c;
    logic           go_c;
    logic [CW-1:0]  tr_min;
    logic [CW-1:0]  tr_c;
    logic [CW-1:0]  nl_pos;
    logic           rd_read;
    logic [1:0]     rstat_c;

    logic [CW-1:0]  st_dec;
    logic           out_free;
    tild_pkg::t_out_item res;

    assign canon = r_lflags[tild_pkg::LF_CANON];

    always_comb begin
        b0       = r_iflags[tild_pkg::IF_STRIP] ? (r_in.char_in & tild_pkg::STRIP_MASK)
                                                 : r_in.char_in;
        e        = 1'b0;
        skip     = 1'b0;
        n_esc_c  = r_esc;
        n_stop_c = r_stop;
        stp      = r_stop;
        act      = tild_pkg::A_NONE;
        if (r_lflags[tild_pkg::LF_EXT]) begin
            if (r_esc) begin
                e       = 1'b1;
                n_esc_c = 1'b0;
            end else if (b0 != tild_pkg::CH_NUL && b0 == r_lnext) begin
                n_esc_c = 1'b1;
                skip    = 1'b1;
            end
        end
        b1 = b0;
        if (!e && b0 == tild_pkg::CH_CR) begin
            if (r_iflags[tild_pkg::IF_IGNCR]) begin
                skip = 1'b1;
            end else if (r_iflags[tild_pkg::IF_CRNL]) begin
                b1 = tild_pkg::CH_NL;
            end
        end else if (!e && b0 == tild_pkg::CH_NL && r_iflags[tild_pkg::IF_NLCR]) begin
            b1 = tild_pkg::CH_CR;
        end
        for (int i = 0; i < 8; i++) begin
            hit[i] = !e && b1 != tild_pkg::CH_NUL && b1 == r_cc[i*8 +: 8];
        end
        nl_c  = (!e && b1 == tild_pkg::CH_NL) || hit[tild_pkg::CC_EOF] || hit[tild_pkg::CC_EOL];
        eof_c = hit[tild_pkg::CC_EOF];
        if (skip) begin
            act = tild_pkg::A_NONE;
        end else if (r_iflags[tild_pkg::IF_XON] && hit[tild_pkg::CC_STOP]) begin
            n_stop_c = 1'b1;
        end else if (r_iflags[tild_pkg::IF_XON] && hit[tild_pkg::CC_START]) begin
            n_stop_c = 1'b0;
        end else begin
            if (r_iflags[tild_pkg::IF_XON] && r_stop && r_iflags[tild_pkg::IF_XANY]) begin
                stp = 1'b0;
            end
            n_stop_c = stp;
            if (stp) begin
                act = tild_pkg::A_NONE;
            end else if (canon && hit[tild_pkg::CC_ERASE]) begin
                act = (r_linelen != '0) ? tild_pkg::A_ERASE : tild_pkg::A_NONE;
            end else if (canon && hit[tild_pkg::CC_KILL]) begin
                act = (r_linelen != '0) ? tild_pkg::A_KILL : tild_pkg::A_NONE;
            end else if (r_lflags[tild_pkg::LF_SIG] && r_fg && hit[tild_pkg::CC_INTR]) begin
                act = tild_pkg::A_INTR;
            end else if (r_lflags[tild_pkg::LF_SIG] && r_fg && hit[tild_pkg::CC_QUIT]) begin
                act = tild_pkg::A_QUIT;
            end else if (r_stored < CW'(DEPTH)) begin
                act = tild_pkg::A_STORE;
            end
        end
    end

    always_comb begin
        if (act == tild_pkg::A_STORE) begin
            rd_byte = canon ? (r_lc != '0 || nl_c) : 1'b1;
        end else begin
            rd_byte = canon ? (r_lc != '0) : (r_stored != '0);
        end
    end

    assign tail_sum = (CW+1)'(r_head) + (CW+1)'(r_stored);
    assign tail     = (tail_sum >= (CW+1)'(DEPTH)) ? IW'(tail_sum - (CW+1)'(DEPTH))
                                                   : IW'(tail_sum);
    assign wdata    = {eof_c, nl_c, e, b1};

    tild_ram #(
        .WIDTH(tild_pkg::ENTRY_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.classify && act == tild_pkg::A_STORE),
        .i_waddr (tail),
        .i_wdata (wdata),
        .i_raddr (r_head),
        .o_rdata (rdata)
    );

    always_comb begin
        size_x  = SW'(r_in.read_size);
        st_x    = SW'(r_stored);
        all_c   = canon ? (r_lc != '0) : (st_x >= size_x);
        go_c    = r_in.nonblock || all_c;
        tr_min  = (size_x < st_x) ? CW'(size_x) : r_stored;
        tr_c    = (!canon || all_c) ? tr_min : '0;
        nl_pos  = r_stored - r_linelen - CW'(1);
        if (!go_c) begin
            rd_read = canon ? (r_lc != '0) : (r_stored != '0);
            rstat_c = tild_pkg::RS_NOTREADY;
        end else begin
            if (!canon) begin
                rd_read = size_x < st_x;
            end else begin
                rd_read = (r_lc > CW'(1)) || (r_lc == CW'(1) && nl_pos >= tr_c);
            end
            rstat_c = all_c ? tild_pkg::RS_SUCCESS : tild_pkg::RS_WOULDBLK;
        end
    end

    assign st_dec = r_stored - CW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iflags <= tild_pkg::IFLAGS_RST;
            r_lflags <= tild_pkg::LFLAGS_RST;
            r_cc     <= tild_pkg::CC_RST;
            r_lnext  <= tild_pkg::LNEXT_RST;
            r_fg     <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tild_pkg::CFG_IFLAGS: r_iflags <= i_cfg_data[5:0];
                tild_pkg::CFG_LFLAGS: r_lflags <= i_cfg_data[6:0];
                tild_pkg::CFG_CC:     r_cc     <= i_cfg_data;
                tild_pkg::CFG_LNEXT:  r_lnext  <= i_cfg_data[7:0];
                tild_pkg::CFG_FG:     r_fg     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_stored  <= '0;
            r_lc      <= '0;
            r_linelen <= '0;
            r_esc     <= 1'b0;
            r_stop    <= 1'b0;
            r_act     <= tild_pkg::A_NONE;
        end else if (i_cmd.accept && i_in_item.cmd == tild_pkg::C_FLUSH) begin
            r_head    <= '0;
            r_stored  <= '0;
            r_lc      <= '0;
            r_linelen <= '0;
        end else if (i_cmd.classify) begin
            r_esc  <= n_esc_c;
            r_stop <= n_stop_c;
            r_act  <= act;
            unique case (act)
                tild_pkg::A_STORE: begin
                    r_stored  <= r_stored + CW'(1);
                    r_lc      <= nl_c ? r_lc + CW'(1) : r_lc;
                    r_linelen <= nl_c ? '0 : r_linelen + CW'(1);
                end
                tild_pkg::A_ERASE: begin
                    r_stored  <= st_dec;
                    r_linelen <= r_linelen - CW'(1);
                end
                tild_pkg::A_KILL: begin
                    r_stored  <= r_stored - r_linelen;
                    r_linelen <= '0;
                end
                default: ;
            endcase
        end else if (i_cmd.pop) begin
            r_head    <= (r_head == IW'(DEPTH - 1)) ? '0 : r_head + IW'(1);
            r_stored  <= st_dec;
            if (rdata[tild_pkg::E_NL] && r_lc != '0) begin
                r_lc <= r_lc - CW'(1);
            end
            if (r_linelen > st_dec) begin
                r_linelen <= st_dec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_in <= i_in_item;
        end
        if (i_cmd.classify) begin
            r_chb <= b1;
            r_che <= e;
            r_rd  <= rd_byte;
            if (act == tild_pkg::A_KILL) begin
                r_kcnt <= (SW'(r_linelen) > SW'(tild_pkg::KILL_ECHO_MAX))
                          ? tild_pkg::KILL_ECHO_MAX : 5'(r_linelen);
            end else begin
                r_kcnt <= 5'd1;
            end
        end else if (i_cmd.kdec) begin
            r_kcnt <= r_kcnt - 5'd1;
        end
        if (i_cmd.rsetup) begin
            r_tr    <= tr_c;
            r_i     <= '0;
            r_n     <= '0;
            r_rd    <= rd_read;
            r_rstat <= rstat_c;
        end else if (i_cmd.pop) begin
            r_i <= r_i + CW'(1);
            if (i_cmd.emit) begin
                r_n <= r_n + CW'(1);
            end
        end
    end

    always_comb begin
        res             = '0;
        res.kind        = tild_pkg::K_ECHO;
        res.readable    = r_rd;
        unique case (i_cmd.sel)
            tild_pkg::R_CHAR1: res.data_byte = o_stat.caret ? tild_pkg::CH_CARET : r_chb;
            tild_pkg::R_CHAR2: res.data_byte = tild_pkg::CH_AT + r_chb;
            tild_pkg::R_BS:    res.data_byte = tild_pkg::CH_BS;
            tild_pkg::R_SP:    res.data_byte = tild_pkg::CH_SP;
            tild_pkg::R_NL:    res.data_byte = tild_pkg::CH_NL;
            tild_pkg::R_SIG: begin
                res.kind = (r_act == tild_pkg::A_INTR) ? tild_pkg::K_INTR : tild_pkg::K_QUIT;
            end
            tild_pkg::R_RBYTE: begin
                res.kind      = tild_pkg::K_READ;
                res.data_byte = rdata[7:0];
            end
            tild_pkg::R_RDONE: begin
                res.kind        = tild_pkg::K_DONE;
                res.read_status = r_rstat;
                res.transferred = 5'(r_n);
            end
            default: ;
        endcase
    end

    assign out_free = !r_out_v || !i_out_stall;

    always_comb begin
        pend_last      = r_pend;
        pend_last.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_pend_v <= 1'b1;
            end else if (i_cmd.finish) begin
                r_pend_v <= 1'b0;
            end
            if ((i_cmd.emit && r_pend_v) || i_cmd.finish) begin
                r_out_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_pend <= res;
        end
        if (i_cmd.emit && r_pend_v) begin
            r_out <= r_pend;
        end else if (i_cmd.finish) begin
            r_out <= pend_last;
        end
    end

    always_comb begin
        o_stat            = '0;
        o_stat.act_now    = act;
        o_stat.act_q      = r_act;
        o_stat.echo_ch    = r_lflags[tild_pkg::LF_ECHO]
                            || (r_chb == tild_pkg::CH_NL && canon
                                && r_lflags[tild_pkg::LF_ECHONL]);
        o_stat.caret      = r_chb < tild_pkg::CTRL_LIM
                            && (r_che || (r_chb != tild_pkg::CH_NL && r_chb != tild_pkg::CH_CR
                                          && r_chb != tild_pkg::CH_TAB));
        o_stat.echo_on    = r_lflags[tild_pkg::LF_ECHO];
        o_stat.echo_erase = r_lflags[tild_pkg::LF_ECHOE];
        o_stat.kill_nl    = r_lflags[tild_pkg::LF_ECHOK]
                            && (r_lflags[tild_pkg::LF_ECHO] || r_lflags[tild_pkg::LF_ECHONL]);
        o_stat.go_now     = go_c;
        o_stat.rd_more    = r_i < r_tr;
        o_stat.rd_emit    = !(canon && rdata[tild_pkg::E_NL] && rdata[tild_pkg::E_EOF]);
        o_stat.rd_stop    = canon && rdata[tild_pkg::E_NL];
        o_stat.kcnt_one   = r_kcnt == 5'd1;
        o_stat.emit_ok    = !r_pend_v || out_free;
        o_stat.out_free   = out_free;
        o_stat.pend_v     = r_pend_v;
    end

    assign o_out_valid = r_out_v;
    assign o_out_item  = r_out;

endmodule

@@ rtl/core/tty_input_line_discipline.sv @@
// Top level of the tty input line discipline: controller and datapath.
// Depends on tild_pkg, tild_ctrl, tild_dp and tild_ram.
//
//  Channel   Direction  Handshake            Payload
//  input     in         i_in_valid/o_in_stall  tild_pkg::t_in_item
//  result    out        o_out_valid/i_out_stall tild_pkg::t_out_item
//  config    in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// One item is processed at a time. A received byte is accepted and classified, then its echo
// results are emitted, and the last one, if any, is released in the done state.
// Kill needs no buffer scan: the length of the current line is tracked.
// A read is set up, then takes each buffer entry through a request state and a get state, as the
// read port is registered; a line end stops it, and a read that is not ready goes to its done result.
// Reset is synchronous and clears all control state; the buffer needs no clearing.
// A stalled result holds; the block waits with the next result until it moves on.
module tty_input_line_discipline #(
    parameter int BUFFER_DEPTH = tild_pkg::BUFFER_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tild_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tild_pkg::t_out_item o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [63:0]         i_cfg_data
);

    tild_pkg::t_dp_cmd  cmd;
    tild_pkg::t_dp_stat stat;
    logic               idle;

    tild_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_cmd   (i_in_item.cmd),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_idle     (idle)
    );

    tild_dp #(
        .DEPTH(BUFFER_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    assign o_in_stall  = !idle;
    assign o_cfg_ready = 1'b1;

endmodule
